[rtl/core/cofr_pkg.sv]
package cofr_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic REG_NODE_ID  = 1'b0;
  localparam logic REG_HB_PERIOD = 1'b1;

  localparam logic [6:0]  NODE_ID_RESET   = 7'd1;
  localparam logic [15:0] HB_PERIOD_RESET = 16'd1000;

  // Item kinds
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;
  localparam logic [1:0] ST_NMT_BAD = 2'd3;

  // NMT states
  localparam logic [6:0] NMT_PREOP = 7'h7F;
  localparam logic [6:0] NMT_OPER  = 7'h05;
  localparam logic [6:0] NMT_STOP  = 7'h04;

  // NMT commands
  localparam logic [7:0] NMT_CMD_START      = 8'h01;
  localparam logic [7:0] NMT_CMD_STOP       = 8'h02;
  localparam logic [7:0] NMT_CMD_PREOP      = 8'h80;
  localparam logic [7:0] NMT_CMD_RESET_NODE = 8'h81;
  localparam logic [7:0] NMT_CMD_RESET_COMM = 8'h82;

  // Operating modes (DS402)
  localparam logic [7:0] MODE_CSP = 8'd8;
  localparam logic [7:0] MODE_CSV = 8'd9;
  localparam logic [7:0] MODE_CST = 8'd10;

  // Reference kinds on the result side
  localparam logic [1:0] CM_TORQUE   = 2'd0;
  localparam logic [1:0] CM_VELOCITY = 2'd1;
  localparam logic [1:0] CM_POSITION = 2'd3;

  // Function codes, identifier bits 10..7
  localparam logic [3:0] FC_RPDO1 = 4'h4;
  localparam logic [3:0] FC_RPDO2 = 4'h6;
  localparam logic [3:0] FC_RPDO3 = 4'h8;
  localparam logic [3:0] FC_RPDO4 = 4'hA;
  localparam logic [3:0] FC_RSDO  = 4'hC;

  // SDO command specifiers, byte 0 bits 7..5
  localparam logic [2:0] SDO_CS_DOWNLOAD = 3'd1;
  localparam logic [2:0] SDO_CS_UPLOAD   = 3'd2;

  // Object dictionary indexes
  localparam logic [15:0] OBJ_CONTROLWORD = 16'h6040;
  localparam logic [15:0] OBJ_MODES       = 16'h6060;
  localparam logic [15:0] OBJ_TORQUE      = 16'h6071;
  localparam logic [15:0] OBJ_POSITION    = 16'h607A;
  localparam logic [15:0] OBJ_VELOCITY    = 16'h60FF;

  typedef struct packed {
    logic        op;
    logic [10:0] can_id;
    logic [3:0]  frame_len;
    logic [63:0] payload;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ctrl_word_valid;
    logic [15:0] ctrl_word;
    logic        drive_enable;
    logic        target_valid;
    logic [1:0]  ref_kind;
    logic signed [31:0] target_value;
    logic        param_read;
    logic [15:0] read_index;
    logic        system_reset;
    logic        heartbeat_valid;
    logic [6:0]  heartbeat_byte;
  } result_t;

  typedef struct packed {
    logic [6:0]  node_id;
    logic [15:0] heartbeat_period;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  nmt_state;
    logic [7:0]  operating_mode;
    logic [31:0] last_heartbeat;
  } node_state_t;

endpackage

[rtl/core/cofr_cfg_regs.sv]
module cofr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cofr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cofr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cofr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output cofr_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write the addressed register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id          <= cofr_pkg::NODE_ID_RESET;
      cfg.heartbeat_period <= cofr_pkg::HB_PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        cofr_pkg::REG_NODE_ID:   cfg.node_id          <= pwdata[6:0];
        cofr_pkg::REG_HB_PERIOD: cfg.heartbeat_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      cofr_pkg::REG_NODE_ID:   prdata = {25'd0, cfg.node_id};
      cofr_pkg::REG_HB_PERIOD: prdata = {16'd0, cfg.heartbeat_period};
      default:                 prdata = '0;
    endcase
  end

endmodule

[rtl/core/cofr_decode.sv]
module cofr_decode (
  input  cofr_pkg::item_t        item,
  input  cofr_pkg::cfg_t         cfg,
  input  cofr_pkg::node_state_t  state,
  output cofr_pkg::result_t      result,
  output cofr_pkg::node_state_t  state_next
);

  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [15:0] low_word;
  logic [15:0] mid_word;
  logic [31:0] high_word;
  logic [15:0] obj_index;
  logic        len_ge2;
  logic        len_ge4;
  logic        len_ge8;
  logic [31:0] elapsed;
  logic        hb_due;

  assign byte0     = item.payload[7:0];
  assign byte1     = item.payload[15:8];
  assign low_word  = item.payload[15:0];
  assign mid_word  = item.payload[31:16];
  assign high_word = item.payload[63:32];
  assign obj_index = item.payload[23:8];

  // Lengths nine to fifteen count as eight bytes
  assign len_ge2 = item.frame_len >= 4'd2;
  assign len_ge4 = item.frame_len >= 4'd4;
  assign len_ge8 = item.frame_len >= 4'd8;

  // Elapsed time wraps modulo 2^32
  assign elapsed = item.now_ms - state.last_heartbeat;
  assign hb_due  = (cfg.heartbeat_period != 16'd0) &&
                   (elapsed >= {16'd0, cfg.heartbeat_period});

  always_comb begin
    result     = '0;
    result.status = cofr_pkg::ST_OK;
    state_next = state;

    if (item.op == cofr_pkg::OP_TICK) begin
      // Heartbeat tick
      if (hb_due) begin
        state_next.last_heartbeat = item.now_ms;
        result.heartbeat_valid    = 1'b1;
        result.heartbeat_byte     = state.nmt_state;
      end
    end else if (item.can_id == 11'd0) begin
      // NMT command
      if (!len_ge2) begin
        result.status = cofr_pkg::ST_NMT_BAD;
      end else if (byte1 != 8'd0 && byte1 != {1'b0, cfg.node_id}) begin
        result.status = cofr_pkg::ST_NMT_BAD;
      end else begin
        unique case (byte0)
          cofr_pkg::NMT_CMD_START:      state_next.nmt_state = cofr_pkg::NMT_OPER;
          cofr_pkg::NMT_CMD_STOP:       state_next.nmt_state = cofr_pkg::NMT_STOP;
          cofr_pkg::NMT_CMD_PREOP:      state_next.nmt_state = cofr_pkg::NMT_PREOP;
          cofr_pkg::NMT_CMD_RESET_NODE: result.system_reset  = 1'b1;
          cofr_pkg::NMT_CMD_RESET_COMM: begin
            state_next.nmt_state      = cofr_pkg::NMT_PREOP;
            state_next.operating_mode = cofr_pkg::MODE_CST;
            state_next.last_heartbeat = 32'd0;
          end
          default: result.status = cofr_pkg::ST_NMT_BAD;
        endcase
      end
    end else if (item.can_id[6:0] != cfg.node_id) begin
      result.status = cofr_pkg::ST_INVALID;
    end else begin
      unique case (item.can_id[10:7])
        cofr_pkg::FC_RPDO1, cofr_pkg::FC_RPDO2,
        cofr_pkg::FC_RPDO3, cofr_pkg::FC_RPDO4: begin
          // Controlword plus a mode-dependent target
          if (!len_ge2) begin
            result.status = cofr_pkg::ST_INVALID;
          end else begin
            result.ctrl_word_valid = 1'b1;
            result.ctrl_word       = low_word;
            result.drive_enable    = low_word[3];
            if (len_ge4) begin
              unique case (state.operating_mode)
                cofr_pkg::MODE_CST: begin
                  result.target_valid = 1'b1;
                  result.ref_kind     = cofr_pkg::CM_TORQUE;
                end
                cofr_pkg::MODE_CSV: begin
                  result.target_valid = 1'b1;
                  result.ref_kind     = cofr_pkg::CM_VELOCITY;
                end
                cofr_pkg::MODE_CSP: begin
                  result.target_valid = 1'b1;
                  result.ref_kind     = cofr_pkg::CM_POSITION;
                end
                default: ;
              endcase
              if (result.target_valid) begin
                result.target_value = {{16{mid_word[15]}}, mid_word};
              end
            end
          end
        end
        cofr_pkg::FC_RSDO: begin
          // Expedited SDO
          if (!len_ge8) begin
            result.status = cofr_pkg::ST_INVALID;
          end else begin
            unique case (byte0[7:5])
              cofr_pkg::SDO_CS_DOWNLOAD: begin
                unique case (obj_index)
                  cofr_pkg::OBJ_CONTROLWORD: ;
                  cofr_pkg::OBJ_MODES: state_next.operating_mode = high_word[7:0];
                  cofr_pkg::OBJ_TORQUE: begin
                    result.target_valid = 1'b1;
                    result.ref_kind     = cofr_pkg::CM_TORQUE;
                    result.target_value = {{16{high_word[15]}}, high_word[15:0]};
                  end
                  cofr_pkg::OBJ_VELOCITY: begin
                    result.target_valid = 1'b1;
                    result.ref_kind     = cofr_pkg::CM_VELOCITY;
                    result.target_value = high_word;
                  end
                  cofr_pkg::OBJ_POSITION: begin
                    result.target_valid = 1'b1;
                    result.ref_kind     = cofr_pkg::CM_POSITION;
                    result.target_value = high_word;
                  end
                  default: result.status = cofr_pkg::ST_UNSUP;
                endcase
              end
              cofr_pkg::SDO_CS_UPLOAD: begin
                result.param_read = 1'b1;
                result.read_index = obj_index;
              end
              default: result.status = cofr_pkg::ST_UNSUP;
            endcase
          end
        end
        default: result.status = cofr_pkg::ST_UNSUP;
      endcase
    end
  end

endmodule

[rtl/core/canopen_frame_receiver.sv]
// CANopen DS402 slave receiver. Each beat on the item channel is either a
// received CAN frame (op 0) or a millisecond time tick (op 1), and gives
// exactly one beat on the result channel. The block takes one item per
// clock while item_stall is low: an item is registered, decoded
// combinationally against the node state (NMT state, operating mode,
// last heartbeat time) and the result is registered, so result_valid
// rises once the item moves from the input register to the result register.
// The node state is updated in the same cycle as the decode, so the next
// item always sees the effect of the one before. item_stall rises only
// when the result register is full and stalled. node_id sits at address 0
// and heartbeat_period at address 4; write them only while no item is in
// flight. An NMT reset-node request shows up as system_reset and leaves
// the node state untouched; the system reset that follows clears it.
module canopen_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  cofr_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output cofr_pkg::result_t                result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cofr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cofr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cofr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  cofr_pkg::cfg_t         cfg;
  cofr_pkg::item_t        item_q;
  logic                   item_q_valid;
  cofr_pkg::node_state_t  node_state;
  cofr_pkg::node_state_t  node_state_next;
  cofr_pkg::result_t      dec_result;
  logic                   advance;
  logic                   accept;

  cofr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cofr_decode u_decode (
    .item       (item_q),
    .cfg        (cfg),
    .state      (node_state),
    .result     (dec_result),
    .state_next (node_state_next)
  );

  // Move the held item on when the result register is free or drains
  assign advance    = item_q_valid & (~result_valid | ~result_stall);
  assign item_stall = item_q_valid & ~advance;
  assign accept     = item_valid & ~item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (accept) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  // Node state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_state.nmt_state      <= cofr_pkg::NMT_PREOP;
      node_state.operating_mode <= cofr_pkg::MODE_CST;
      node_state.last_heartbeat <= 32'd0;
    end else if (advance) begin
      node_state <= node_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= dec_result;
    end
  end

  // A failed item never carries controlword, target or read request
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != cofr_pkg::ST_OK) |->
      (!result.ctrl_word_valid && !result.target_valid && !result.param_read))
    else $error("failed item carries payload");

  // Reset-node leaves the node state alone
  assert property (@(posedge clk) disable iff (rst)
    (advance && dec_result.system_reset) |=> (node_state == $past(node_state)))
    else $error("reset-node changed node state");

  // An emitted heartbeat restarts the period at the tick time
  assert property (@(posedge clk) disable iff (rst)
    (advance && dec_result.heartbeat_valid) |=>
      (node_state.last_heartbeat == $past(item_q.now_ms)))
    else $error("heartbeat time not captured");

  // A heartbeat beat comes only from a tick and carries nothing else
  assert property (@(posedge clk) disable iff (rst)
    (advance && dec_result.heartbeat_valid) |->
      (item_q.op == cofr_pkg::OP_TICK && !dec_result.target_valid &&
       dec_result.status == cofr_pkg::ST_OK))
    else $error("heartbeat on a non-tick item");

endmodule
